[rtl/core/iog_pkg.sv]
// ----------------------------------------------------------------------------
// iog_pkg
// Shared types and constants of the interior offset generator.
// ----------------------------------------------------------------------------
package iog_pkg;

   // Number of image dimensions in use (1 to 3). Dimensions at or beyond
   // this count behave as size 3 with stride 0.
   localparam int NUM_DIMS = 3;

   localparam int SIZE_W    = 16;
   localparam int STRIDE_W  = 32;
   localparam int PART_W    = 48;
   localparam int OFFSET_W  = 50;
   localparam int CSR_IDX_W = 3;

   // Register map.
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_USE_MASK = 3'd6;

   localparam logic [1:0] DIM_X = 2'd0;
   localparam logic [1:0] DIM_Y = 2'd1;
   localparam logic [1:0] DIM_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd3;

   // Control word that the top level hands to each dimension counter.
   typedef struct packed {
      logic                step;
      logic                wr_size;
      logic                wr_stride;
      logic [STRIDE_W-1:0] wdata;
   } iog_dim_ctrl_type;

   function automatic logic signed [STRIDE_W-1:0] stride_reset(input logic [1:0] dim);
      logic signed [STRIDE_W-1:0] val;
      val = (dim == DIM_X) ? 32'sd1 : 32'sd0;
      return val;
   endfunction

endpackage

[rtl/core/iog_dim.sv]
// ----------------------------------------------------------------------------
// iog_dim
// One dimension of the walk: size and stride registers, the interior
// coordinate counter and the running partial offset coord * stride.
// ----------------------------------------------------------------------------
module iog_dim (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [1:0]                            dim_sel,
   input  iog_pkg::iog_dim_ctrl_type             ctrl,
   output logic                                  at_end,
   output logic signed [iog_pkg::PART_W-1:0]     partial
);

   logic [iog_pkg::SIZE_W-1:0]             size_ff, size_in;
   logic signed [iog_pkg::STRIDE_W-1:0]    stride_ff, stride_in;
   logic [iog_pkg::SIZE_W-1:0]             coord_ff, coord_in;
   logic signed [iog_pkg::PART_W-1:0]      part_ff, part_in;

   logic                                   enabled;
   logic [iog_pkg::SIZE_W-1:0]             size_eff;
   logic [iog_pkg::SIZE_W-1:0]             last_coord;
   logic signed [iog_pkg::STRIDE_W-1:0]    stride_eff;
   logic signed [iog_pkg::PART_W-1:0]      stride_ext;
   logic signed [iog_pkg::SIZE_W+iog_pkg::STRIDE_W:0] product;

   assign enabled = ({30'd0, dim_sel} < iog_pkg::NUM_DIMS);

   // Sizes below three, and unused dimensions, give a single interior line.
   assign size_eff   = (!enabled || size_ff < iog_pkg::SIZE_RESET) ? iog_pkg::SIZE_RESET
                                                                   : size_ff;
   assign last_coord = size_eff - 16'd2;
   assign at_end     = (coord_ff >= last_coord);

   assign stride_eff = enabled ? stride_ff : '0;
   assign stride_ext = {{(iog_pkg::PART_W-iog_pkg::STRIDE_W){stride_eff[iog_pkg::STRIDE_W-1]}},
                        stride_eff};

   // A new stride restarts the partial at the current coordinate.
   assign product = $signed({1'b0, coord_ff}) * $signed(ctrl.wdata);

   always_comb begin
      size_in   = size_ff;
      stride_in = stride_ff;
      coord_in  = coord_ff;
      part_in   = part_ff;
      if (ctrl.wr_size) begin
         size_in = ctrl.wdata[iog_pkg::SIZE_W-1:0];
      end
      if (ctrl.wr_stride) begin
         stride_in = $signed(ctrl.wdata);
         part_in   = enabled ? product[iog_pkg::PART_W-1:0] : '0;
      end
      if (ctrl.step) begin
         if (at_end) begin
            coord_in = 16'd1;
            part_in  = stride_ext;
         end else begin
            coord_in = coord_ff + 16'd1;
            part_in  = part_ff + stride_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= iog_pkg::SIZE_RESET;
         stride_ff <= iog_pkg::stride_reset(dim_sel);
         coord_ff  <= 16'd1;
         part_ff   <= enabled ? {{(iog_pkg::PART_W-iog_pkg::STRIDE_W){1'b0}},
                                 iog_pkg::stride_reset(dim_sel)} : '0;
      end else begin
         size_ff   <= size_in;
         stride_ff <= stride_in;
         coord_ff  <= coord_in;
         part_ff   <= part_in;
      end
   end

   assign partial = part_ff;

endmodule

[rtl/core/interior_offset_generator.sv]
// ----------------------------------------------------------------------------
// interior_offset_generator
// Scan-order walk over the interior of a 1D to 3D image, one offset per word.
// ----------------------------------------------------------------------------
// Each accepted request word (one mask bit) yields exactly one response word
// with the linear offset coord_x*stride_x + coord_y*stride_y + coord_z*stride_z
// of the current interior position, a keep flag and a last flag, after which
// the position advances (x fastest) and wraps to (1,1,1) after the final one.
// Throughput is one word per cycle while rsp_stall is low, and the response
// is registered: every dimension keeps its partial product as a running sum
// that is updated by an add, and only the three-way add into the response
// register lies in the path. A stride write recomputes that dimension's
// partial with one 16x32 multiply in the same cycle. Configuration must only
// be written while the block is idle; the write channel is always ready.
module interior_offset_generator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_mask_bit,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [iog_pkg::OFFSET_W-1:0]     rsp_offset,
   output logic                                    rsp_keep,
   output logic                                    rsp_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [iog_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [iog_pkg::STRIDE_W-1:0]            csr_wdata
);

   logic                                  accept;
   logic                                  csr_wr;
   logic                                  end_x, end_y, end_z;
   logic signed [iog_pkg::PART_W-1:0]     part_x, part_y, part_z;
   iog_pkg::iog_dim_ctrl_type             ctrl_x, ctrl_y, ctrl_z;

   logic                                  use_mask_ff, use_mask_in;
   logic                                  valid_ff, valid_in;
   logic [iog_pkg::OFFSET_W-1:0]          offset_ff, offset_in;
   logic                                  keep_ff, keep_in;
   logic                                  last_ff, last_in;

   // The response register is free when empty or being drained this cycle.
   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      ctrl_x.step      = accept;
      ctrl_x.wr_size   = csr_wr && (csr_index == iog_pkg::REG_SIZE_X);
      ctrl_x.wr_stride = csr_wr && (csr_index == iog_pkg::REG_STRIDE_X);
      ctrl_x.wdata     = csr_wdata;
      ctrl_y.step      = accept && end_x;
      ctrl_y.wr_size   = csr_wr && (csr_index == iog_pkg::REG_SIZE_Y);
      ctrl_y.wr_stride = csr_wr && (csr_index == iog_pkg::REG_STRIDE_Y);
      ctrl_y.wdata     = csr_wdata;
      ctrl_z.step      = accept && end_x && end_y;
      ctrl_z.wr_size   = csr_wr && (csr_index == iog_pkg::REG_SIZE_Z);
      ctrl_z.wr_stride = csr_wr && (csr_index == iog_pkg::REG_STRIDE_Z);
      ctrl_z.wdata     = csr_wdata;
   end

   iog_dim u_dim_x (
      .clock   (clock),
      .reset   (reset),
      .dim_sel (iog_pkg::DIM_X),
      .ctrl    (ctrl_x),
      .at_end  (end_x),
      .partial (part_x)
   );

   iog_dim u_dim_y (
      .clock   (clock),
      .reset   (reset),
      .dim_sel (iog_pkg::DIM_Y),
      .ctrl    (ctrl_y),
      .at_end  (end_y),
      .partial (part_y)
   );

   iog_dim u_dim_z (
      .clock   (clock),
      .reset   (reset),
      .dim_sel (iog_pkg::DIM_Z),
      .ctrl    (ctrl_z),
      .at_end  (end_z),
      .partial (part_z)
   );

   always_comb begin
      use_mask_in = use_mask_ff;
      if (csr_wr && (csr_index == iog_pkg::REG_USE_MASK)) begin
         use_mask_in = csr_wdata[0];
      end

      valid_in  = valid_ff;
      offset_in = offset_ff;
      keep_in   = keep_ff;
      last_in   = last_ff;
      if (accept) begin
         valid_in  = 1'b1;
         offset_in = {{2{part_x[iog_pkg::PART_W-1]}}, part_x}
                   + {{2{part_y[iog_pkg::PART_W-1]}}, part_y}
                   + {{2{part_z[iog_pkg::PART_W-1]}}, part_z};
         keep_in   = use_mask_ff ? req_mask_bit : 1'b1;
         last_in   = end_x && end_y && end_z;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_mask_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         use_mask_ff <= use_mask_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      keep_ff   <= keep_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_offset = $signed(offset_ff);
   assign rsp_keep   = keep_ff;
   assign rsp_last   = last_ff;

endmodule
